// ===== hw/rtl/gcc_pkg.sv =====
package gcc_pkg;

    localparam int COLOUR_W = 17;
    localparam int COORD_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_VAL_W = 6;
    localparam int PIX_W = 32;

    localparam logic [COLOUR_W-1:0] UNIT_ONE = 17'd65536;
    localparam logic [16:0] DIV255_MUL = 17'd65794;
    localparam int DIV255_SHIFT = 24;
    localparam logic [7:0] BYTE_MAX = 8'd255;
    localparam logic [15:0] BLEND_ROUND = 16'd127;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_BLEND = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_NONE  = 2'd3
    } gcc_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_WIDTH  = 2'd0,
        REG_TARGET_HEIGHT = 2'd1,
        REG_UNUSED_2      = 2'd2,
        REG_UNUSED_3      = 2'd3
    } gcc_reg_idx_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [7:0]          coverage;
        logic [COLOUR_W-1:0] colour_red;
        logic [COLOUR_W-1:0] colour_green;
        logic [COLOUR_W-1:0] colour_blue;
        logic [COLOUR_W-1:0] fill_alpha;
    } gcc_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_alpha;
        logic       in_bounds;
    } gcc_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } gcc_cfg_t;

    typedef struct packed {
        logic calc;
        logic mix;
    } gcc_math_ctl_t;

    function automatic logic [COLOUR_W-1:0] clamp_unit(input logic [COLOUR_W-1:0] v);
        return (v > UNIT_ONE) ? UNIT_ONE : v;
    endfunction

endpackage

// ===== hw/rtl/gcc_chan_if.sv =====
interface gcc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gcc_frame_mem.sv =====
module gcc_frame_mem
    import gcc_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [PIX_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/gcc_pixel_math.sv =====
module gcc_pixel_math
    import gcc_pkg::*;
(
    input  logic                clk,
    input  gcc_math_ctl_t       ctl,
    input  logic                is_clear,
    input  logic [COLOUR_W-1:0] c_blue,
    input  logic [COLOUR_W-1:0] c_green,
    input  logic [COLOUR_W-1:0] c_red,
    input  logic [COLOUR_W-1:0] c_alpha,
    input  logic [7:0]          cov,
    input  logic [PIX_W-1:0]    dst,
    output logic [PIX_W-1:0]    pix
);

    // lanes: 0 blue, 1 green, 2 red, 3 alpha
    logic [COLOUR_W-1:0] chan_c [3];
    logic [33:0]         prod_reg [3];
    logic [7:0]          byte_reg [4];
    logic [15:0]         t_reg [4];
    logic [7:0]          byte_next [4];
    logic [15:0]         t_next [4];
    logic [7:0]          out_byte [4];
    logic [COLOUR_W-1:0] mul_b;
    logic [7:0]          inv;

    assign chan_c[0] = c_blue;
    assign chan_c[1] = c_green;
    assign chan_c[2] = c_red;
    assign mul_b = is_clear ? c_alpha : COLOUR_W'(cov);
    assign inv = BYTE_MAX - cov;

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= 34'(chan_c[i]) * 34'(mul_b);
            end
        end
        if (ctl.mix)
        begin
            for (int i = 0; i < 4; i++)
            begin
                byte_reg[i] <= byte_next[i];
                t_reg[i] <= t_next[i];
            end
        end
    end

    always_comb
    begin
        logic [41:0] clr_sum;
        logic [25:0] a_sum;
        logic [9:0]  clr_byte;
        logic [17:0] src_wide;
        for (int i = 0; i < 3; i++)
        begin
            clr_sum = (42'(prod_reg[i]) << 8) - 42'(prod_reg[i]) + (42'd1 << 31);
            clr_byte = clr_sum[41:32];
            src_wide = prod_reg[i][33:16];
            if (is_clear)
            begin
                byte_next[i] = (clr_byte > 10'(BYTE_MAX)) ? BYTE_MAX : clr_byte[7:0];
            end
            else
            begin
                byte_next[i] = (src_wide > 18'(BYTE_MAX)) ? BYTE_MAX : src_wide[7:0];
            end
            t_next[i] = 16'(dst[8*i +: 8]) * 16'(inv) + BLEND_ROUND;
        end
        a_sum = (26'(c_alpha) << 8) - 26'(c_alpha) + (26'd1 << 15);
        if (is_clear)
        begin
            byte_next[3] = (a_sum[25:16] > 10'(BYTE_MAX)) ? BYTE_MAX : a_sum[23:16];
        end
        else
        begin
            byte_next[3] = cov;
        end
        t_next[3] = 16'(dst[31:24]) * 16'(inv) + BLEND_ROUND;
    end

    // divide by 255 through a reciprocal, exact for the blend range
    always_comb
    begin
        logic [32:0] q_wide;
        logic [8:0]  sum;
        for (int i = 0; i < 4; i++)
        begin
            q_wide = 33'(t_reg[i]) * 33'(DIV255_MUL);
            sum = 9'(byte_reg[i]) + 9'(q_wide >> DIV255_SHIFT);
            if (is_clear)
            begin
                out_byte[i] = byte_reg[i];
            end
            else
            begin
                out_byte[i] = (sum > 9'(BYTE_MAX)) ? BYTE_MAX : sum[7:0];
            end
        end
    end

    assign pix = {out_byte[3], out_byte[2], out_byte[1], out_byte[0]};

endmodule

// ===== hw/rtl/glyph_coverage_compositor.sv =====
// channel  role    payload       beat taken when
// item     sink    gcc_item_t    item.valid && item.ready
// result   source  gcc_result_t  result.valid && result.ready
// cfg      sink    gcc_cfg_t     cfg.valid && cfg.ready
//
// blend, read and the unused code step through accept, memory read and
// multiply, blend multiply, divide by 255 and write back, output load; the output
// load waits until the output register is free, then registers the result
// a clear adds a fill of width*height pixels, one frame-store write per cycle through the write port
// rst_n clears control and sets both sizes to 32; the frame store is not cleared
// the next item is taken while a result waits in the output register; a second
// result then holds until the first is taken
module glyph_coverage_compositor
    import gcc_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    gcc_chan_if.sink   item,
    gcc_chan_if.source result,
    gcc_chan_if.sink   cfg
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CALC = 6'b000010,
        ST_MIX  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FILL = 6'b010000,
        ST_OUT  = 6'b100000
    } gcc_state_t;

    gcc_state_t state_reg, state_next;

    logic [CFG_VAL_W-1:0] target_width_reg, target_height_reg;
    logic [COORD_W-1:0]   w_eff, h_eff;

    logic [1:0]          func_reg;
    logic [AW-1:0]       addr_reg;
    logic                inside_reg;
    logic [7:0]          cov_reg;
    logic [COLOUR_W-1:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [PIX_W-1:0]    fill_reg;
    logic [PIX_W-1:0]    res_pix_reg;
    logic                res_in_reg;
    logic [COORD_W-1:0]  fx_reg, fy_reg;
    logic                out_valid_reg;
    gcc_result_t         out_data_reg;

    logic                item_fire;
    logic                inside_in;
    logic                res_inside;
    logic                fill_last;
    logic                out_free;
    logic                is_blend;
    logic [AW-1:0]       fill_addr;
    logic [PIX_W-1:0]    mem_rd_data;
    logic                mem_wr_en;
    logic [AW-1:0]       mem_wr_addr;
    logic [PIX_W-1:0]    mem_wr_data;
    logic [PIX_W-1:0]    math_pix;
    gcc_math_ctl_t       math_ctl;

    assign w_eff = (32'(target_width_reg) > MAX_SIDE) ? COORD_W'(MAX_SIDE) : target_width_reg;
    assign h_eff = (32'(target_height_reg) > MAX_SIDE) ? COORD_W'(MAX_SIDE) : target_height_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign inside_in = (item.data.pixel_x < w_eff) && (item.data.pixel_y < h_eff);

    assign is_blend = (func_reg == FUNC_BLEND);
    assign res_inside = inside_reg && (func_reg != FUNC_NONE);
    assign fill_last = (fx_reg == w_eff - 1'b1) && (fy_reg == h_eff - 1'b1);
    assign fill_addr = AW'(32'(fy_reg) * MAX_SIDE + 32'(fx_reg));
    assign out_free = !out_valid_reg || result.ready;

    assign math_ctl.calc = (state_reg == ST_CALC);
    assign math_ctl.mix = (state_reg == ST_MIX);

    always_comb
    begin
        mem_wr_en = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = math_pix;
        if (state_reg == ST_DIV && is_blend && inside_reg)
        begin
            mem_wr_en = 1'b1;
        end
        else if (state_reg == ST_FILL)
        begin
            mem_wr_en = 1'b1;
            mem_wr_addr = fill_addr;
            mem_wr_data = fill_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: state_next = ST_MIX;
            ST_MIX:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (func_reg == FUNC_CLEAR && w_eff != '0 && h_eff != '0)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            target_width_reg <= CFG_VAL_W'(32);
            target_height_reg <= CFG_VAL_W'(32);
            out_valid_reg <= 1'b0;
            fx_reg <= '0;
            fy_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.data.index)
                    REG_TARGET_WIDTH:  target_width_reg <= cfg.data.value;
                    REG_TARGET_HEIGHT: target_height_reg <= cfg.data.value;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FILL)
            begin
                if (fx_reg == w_eff - 1'b1)
                begin
                    fx_reg <= '0;
                    fy_reg <= fill_last ? '0 : fy_reg + 1'b1;
                end
                else
                begin
                    fx_reg <= fx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            func_reg <= item.data.func;
            inside_reg <= inside_in;
            addr_reg <= inside_in ?
                AW'(32'(item.data.pixel_y) * MAX_SIDE + 32'(item.data.pixel_x)) : '0;
            cov_reg <= item.data.coverage;
            red_reg <= clamp_unit(item.data.colour_red);
            green_reg <= clamp_unit(item.data.colour_green);
            blue_reg <= clamp_unit(item.data.colour_blue);
            alpha_reg <= clamp_unit(item.data.fill_alpha);
        end
        if (state_reg == ST_DIV)
        begin
            fill_reg <= math_pix;
            res_pix_reg <= !res_inside ? '0 :
                (func_reg == FUNC_READ) ? mem_rd_data : math_pix;
            res_in_reg <= res_inside;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg.out_blue <= res_pix_reg[7:0];
            out_data_reg.out_green <= res_pix_reg[15:8];
            out_data_reg.out_red <= res_pix_reg[23:16];
            out_data_reg.out_alpha <= res_pix_reg[31:24];
            out_data_reg.in_bounds <= res_in_reg;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    gcc_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (state_reg == ST_CALC),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    gcc_pixel_math u_math (
        .clk      (clk),
        .ctl      (math_ctl),
        .is_clear (func_reg == FUNC_CLEAR),
        .c_blue   (blue_reg),
        .c_green  (green_reg),
        .c_red    (red_reg),
        .c_alpha  (alpha_reg),
        .cov      (cov_reg),
        .dst      (mem_rd_data),
        .pix      (math_pix)
    );

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == ST_FILL ||
            (state_reg == ST_DIV && is_blend && inside_reg)))
        else $error("frame store written outside fill or blend write-back");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> state_reg == ST_CALC)
        else $error("accepted beat did not start processing");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished item");

    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> (fx_reg < w_eff && fy_reg < h_eff))
        else $error("fill position outside target");

endmodule

// ===== bench/tb_glyph_coverage_compositor.sv =====
module tb_glyph_coverage_compositor
    import gcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE = 32;
    localparam int RESULT_LATENCY = 5;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int HOLD_CYCLES = 300;
    localparam int FIXED_PHASES = 10;
    localparam int PHASES = 16;
    localparam int ITEMS_PER_PHASE = 124;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        gcc_item_t   beat;
        bit          typed;
        gcc_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    gcc_chan_if #(.payload_t(gcc_item_t))   item_if();
    gcc_chan_if #(.payload_t(gcc_result_t)) result_if();
    gcc_chan_if #(.payload_t(gcc_cfg_t))    cfg_if();

    glyph_coverage_compositor #(
        .MAX_SIDE (SIDE)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    logic [31:0] shadow_frame [SIDE*SIDE];
    bit          filled [SIDE*SIDE];
    logic [5:0]  cfg_width = 6'd32;
    logic [5:0]  cfg_height = 6'd32;

    gcc_result_t pending_pixels [$];
    gcc_result_t want_px;
    int          errors = 0;
    int          quiet_cycles = 0;
    int          send_calm = 0;
    int          recv_calm = 0;
    bit          hold_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [16:0] to_unit(input logic [16:0] v);
        return (v > 17'd65536) ? 17'd65536 : v;
    endfunction

    function automatic logic [7:0] sat8(input bit [63:0] v);
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [7:0] clear_byte(input bit [63:0] c, input bit [63:0] al);
        bit [63:0] p;
        p = c * al * 64'd255 + 64'h8000_0000;
        return sat8(p >> 32);
    endfunction

    function automatic logic [7:0] blend_chan(input int unsigned src, input int unsigned dst,
                                              input int unsigned inv);
        int unsigned v;
        v = src + (dst * inv + 127) / 255;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic gcc_result_t composite_pixel(input gcc_item_t it);
        bit [63:0]   red;
        bit [63:0]   grn;
        bit [63:0]   blu;
        bit [63:0]   alf;
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        int unsigned cov;
        int unsigned inv;
        logic [31:0] fill;
        logic [31:0] dst;
        logic [31:0] pix;
        bit          in_tgt;
        gcc_result_t res;
        red = to_unit(it.colour_red);
        grn = to_unit(it.colour_green);
        blu = to_unit(it.colour_blue);
        alf = to_unit(it.fill_alpha);
        cov = it.coverage;
        w = (cfg_width > SIDE) ? SIDE : cfg_width;
        h = (cfg_height > SIDE) ? SIDE : cfg_height;
        in_tgt = (it.pixel_x < w) && (it.pixel_y < h);
        idx = it.pixel_y * SIDE + it.pixel_x;
        pix = '0;
        case (it.func)
            FUNC_CLEAR:
            begin
                fill = {sat8((alf * 64'd255 + 64'd32768) >> 16), clear_byte(red, alf),
                        clear_byte(grn, alf), clear_byte(blu, alf)};
                for (int y = 0; y < h; y++)
                begin
                    for (int x = 0; x < w; x++)
                    begin
                        shadow_frame[y*SIDE+x] = fill;
                        filled[y*SIDE+x] = 1'b1;
                    end
                end
                if (in_tgt)
                    pix = fill;
            end
            FUNC_BLEND:
            begin
                if (in_tgt)
                begin
                    dst = shadow_frame[idx];
                    inv = 255 - cov;
                    pix[7:0]   = blend_chan(sat8((blu * cov) >> 16), dst[7:0], inv);
                    pix[15:8]  = blend_chan(sat8((grn * cov) >> 16), dst[15:8], inv);
                    pix[23:16] = blend_chan(sat8((red * cov) >> 16), dst[23:16], inv);
                    pix[31:24] = blend_chan(cov, dst[31:24], inv);
                    shadow_frame[idx] = pix;
                end
            end
            FUNC_READ:
            begin
                if (in_tgt)
                    pix = shadow_frame[idx];
            end
            default:
            begin
                in_tgt = 1'b0;
            end
        endcase
        res.out_blue  = pix[7:0];
        res.out_green = pix[15:8];
        res.out_red   = pix[23:16];
        res.out_alpha = pix[31:24];
        res.in_bounds = in_tgt;
        return res;
    endfunction

    function automatic gcc_item_t pixel_op(input gcc_func_t f, input int x, input int y,
                                           input int cov, input int r, input int g,
                                           input int b, input int a);
        gcc_item_t it;
        it.func         = f;
        it.pixel_x      = 6'(x);
        it.pixel_y      = 6'(y);
        it.coverage     = 8'(cov);
        it.colour_red   = 17'(r);
        it.colour_green = 17'(g);
        it.colour_blue  = 17'(b);
        it.fill_alpha   = 17'(a);
        return it;
    endfunction

    function automatic gcc_result_t pixel_bytes(input int b, input int g, input int r,
                                                input int a, input bit in_b);
        gcc_result_t res;
        res.out_blue  = 8'(b);
        res.out_green = 8'(g);
        res.out_red   = 8'(r);
        res.out_alpha = 8'(a);
        res.in_bounds = in_b;
        return res;
    endfunction

    function automatic logic [16:0] rand_colour();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic gcc_item_t random_op();
        gcc_item_t   it;
        int unsigned w;
        int unsigned h;
        int unsigned roll;
        bit          off_target;
        w = (cfg_width > SIDE) ? SIDE : cfg_width;
        h = (cfg_height > SIDE) ? SIDE : cfg_height;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            it.func = FUNC_CLEAR;
        else if (roll < 6)
            it.func = FUNC_NONE;
        else if (roll < 53)
            it.func = FUNC_BLEND;
        else
            it.func = FUNC_READ;
        case ($urandom_range(0, 7))
            0: it.coverage = 8'd0;
            1: it.coverage = 8'd255;
            default: it.coverage = 8'($urandom_range(0, 255));
        endcase
        it.colour_red   = rand_colour();
        it.colour_green = rand_colour();
        it.colour_blue  = rand_colour();
        it.fill_alpha   = rand_colour();
        off_target = (w == 0) || (h == 0) || ($urandom_range(0, 99) < 6);
        if (off_target)
        begin
            it.pixel_x = 6'($urandom_range(0, 63));
            it.pixel_y = 6'($urandom_range(0, 63));
            if (w != 0 && h != 0)
            begin
                if ($urandom_range(0, 1))
                    it.pixel_x = 6'($urandom_range(w, 63));
                else
                    it.pixel_y = 6'($urandom_range(h, 63));
            end
        end
        else
        begin
            it.pixel_x = 6'($urandom_range(0, w - 1));
            it.pixel_y = 6'($urandom_range(0, h - 1));
        end
        // never touch a pixel that no clear has written yet
        if ((it.func == FUNC_BLEND || it.func == FUNC_READ) && !off_target
            && !filled[it.pixel_y * SIDE + it.pixel_x])
            it.func = FUNC_CLEAR;
        return it;
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic push_item(input gcc_item_t beat, input bit typed, input gcc_result_t want);
        int          gap;
        gcc_result_t pred;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= beat;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        pred = composite_pixel(beat);
        pending_pixels.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    task automatic write_reg(input gcc_reg_idx_t idx, input logic [5:0] val);
        gcc_cfg_t w;
        w.index = idx;
        w.value = val;
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= w;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_TARGET_WIDTH:  cfg_width = val;
            REG_TARGET_HEIGHT: cfg_height = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0);
    endtask

    // result channel: random ready gaps, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            if (recv_calm > 0)
            begin
                recv_calm--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 49) == 0)
                    recv_calm = $urandom_range(10, 40);
            end
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_error($sformatf("%0t: pixel beat with nothing pending: %p",
                                       $realtime, result_if.data));
            end
            else
            begin
                want_px = pending_pixels.pop_front();
                if (result_if.data.out_blue !== want_px.out_blue
                    || result_if.data.out_green !== want_px.out_green
                    || result_if.data.out_red !== want_px.out_red
                    || result_if.data.out_alpha !== want_px.out_alpha
                    || result_if.data.in_bounds !== want_px.in_bounds)
                    report_error($sformatf(
                        "%0t: pixel mismatch bgra/in want %h %h %h %h %b got %h %h %h %h %b",
                        $realtime, want_px.out_blue, want_px.out_green, want_px.out_red,
                        want_px.out_alpha, want_px.in_bounds, result_if.data.out_blue,
                        result_if.data.out_green, result_if.data.out_red,
                        result_if.data.out_alpha, result_if.data.in_bounds));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        int        side_w [PHASES];
        int        side_h [PHASES];
        int        fixed_w [FIXED_PHASES];
        int        fixed_h [FIXED_PHASES];
        fixed_w = '{1, 63, 0, 9, 33, 1, 8, 3, 32, 6};
        fixed_h = '{1, 63, 9, 0, 1, 40, 8, 5, 32, 2};
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.data     = '0;
        result_if.ready = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        rows.push_back('{pixel_op(FUNC_CLEAR, 0, 0, 0, 65536, 65536, 65536, 65536),
                         1'b1, pixel_bytes(255, 255, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_READ, 31, 31, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(255, 255, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_READ, 32, 0, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_READ, 0, 63, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_NONE, 1, 1, 255, 65536, 65536, 65536, 65536),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 63, 63, 255, 65536, 65536, 65536, 0),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 5, 5, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(255, 255, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_BLEND, 5, 5, 255, 65536, 0, 0, 0),
                         1'b1, pixel_bytes(0, 0, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_READ, 5, 5, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(0, 0, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_CLEAR, 40, 3, 0, 131071, 131071, 131071, 0),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_READ, 0, 0, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(0, 0, 0, 0, 1'b1)});
        rows.push_back('{pixel_op(FUNC_CLEAR, 2, 2, 0, 65536, 32768, 1, 32768),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 2, 2, 128, 131071, 40000, 65535, 0),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 2, 2, 200, 12345, 65536, 0, 65536),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_READ, 2, 2, 0, 0, 0, 0, 0),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 31, 0, 1, 131071, 131071, 131071, 131071),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_READ, 31, 0, 0, 0, 0, 0, 0),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_BLEND, 0, 31, 254, 65536, 65536, 98304, 1),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_READ, 0, 31, 0, 0, 0, 0, 0),
                         1'b0, pixel_bytes(0, 0, 0, 0, 1'b0)});
        rows.push_back('{pixel_op(FUNC_CLEAR, 31, 31, 0, 65536, 65536, 65536, 131071),
                         1'b1, pixel_bytes(255, 255, 255, 255, 1'b1)});
        rows.push_back('{pixel_op(FUNC_READ, 17, 9, 0, 0, 0, 0, 0),
                         1'b1, pixel_bytes(255, 255, 255, 255, 1'b1)});

        foreach (rows[i])
            push_item(rows[i].beat, rows[i].typed, rows[i].want);
        item_if.valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                side_w[p] = fixed_w[p];
                side_h[p] = fixed_h[p];
            end
            else
            begin
                side_w[p] = $urandom_range(1, 12);
                side_h[p] = $urandom_range(1, 12);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0 || $urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          6'($urandom_range(0, 63)));
            write_reg(REG_TARGET_WIDTH, 6'(side_w[p]));
            write_reg(REG_TARGET_HEIGHT, 6'(side_h[p]));
            cfg_if.valid <= 1'b0;
            if (p == 6)
                hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 7 && k == ITEMS_PER_PHASE / 2)
                begin
                    item_if.valid <= 1'b0;
                    wait_drained();
                end
                push_item(random_op(), 1'b0, pixel_bytes(0, 0, 0, 0, 1'b0));
            end
            item_if.valid <= 1'b0;
            wait_drained();
        end

        repeat (2 * RESULT_LATENCY) @(negedge clk);
        if (pending_pixels.size() != 0)
            report_error($sformatf("%0d pixel results never arrived", pending_pixels.size()));
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
